// ----- src/rect_circle_fill_rasterizer_unit_defines.svh -----
// Assertion macros shared by the fill rasterizer RTL.
`ifndef RECT_CIRCLE_FILL_RASTERIZER_UNIT_DEFINES_SVH
`define RECT_CIRCLE_FILL_RASTERIZER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define RCFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define RCFR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/rcfr_pkg.sv -----
// Types, constants and codes shared by the fill rasterizer modules.
`timescale 1ns / 1ps

package rcfr_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int OUT_CW     = 16;
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int LIM_W      = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
  localparam int RSQ_W      = 2 * COORD_BITS;
  localparam int SQ_W       = 2 * LIM_W;
  localparam int CMD_W      = 2;

  localparam int IN_TDATA_W  = ((5 * COORD_BITS + 4 * CHAN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * OUT_CW + PIX_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_RECT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic REG_BITMAP_WIDTH  = 1'b0;
  localparam logic REG_BITMAP_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] BITMAP_WIDTH_RST  = 16'd640;
  localparam logic [CFG_W-1:0] BITMAP_HEIGHT_RST = 16'd480;

  // One decoded input item.
  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
    logic [COORD_BITS-1:0] radius;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic [CHAN_W-1:0]     alpha;
  } rcfr_cmd_t;

  // One scan position handed from the sequencer to the coverage pipeline.
  typedef struct packed {
    logic                  idle;
    logic                  circle;
    logic                  last;
    logic [LIM_W-1:0]      row;
    logic [LIM_W-1:0]      col;
    logic [COORD_BITS-1:0] center_col;
    logic [COORD_BITS-1:0] center_row;
    logic [RSQ_W-1:0]      rsq;
    logic [PIX_W-1:0]      pixel;
  } rcfr_step_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic valid;
  } rcfr_q_stat_t;

endpackage

// ----- src/rcfr_queue.sv -----
// Short FIFO of scan positions between the sequencer and the coverage pipeline.
`timescale 1ns / 1ps

module rcfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rcfr_pkg::rcfr_step_t push_data,
  input  logic                pop,
  output rcfr_pkg::rcfr_step_t head,
  output rcfr_pkg::rcfr_q_stat_t stat
);
  import rcfr_pkg::*;

  rcfr_step_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.valid = (count_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/rcfr_front.sv -----
// Command decoder and raster scan sequencer with the bitmap size registers.
`timescale 1ns / 1ps

module rcfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [rcfr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                 accept,
  input  rcfr_pkg::rcfr_cmd_t  cmd_in,
  output logic                 push,
  output rcfr_pkg::rcfr_step_t push_data
);
  import rcfr_pkg::*;

  logic [CFG_W-1:0]      bitmap_width_r, bitmap_height_r;
  logic                  busy_r, busy_nxt;
  logic                  circle_r, circle_nxt;
  logic [LIM_W-1:0]      scan_col_r, scan_col_nxt;
  logic [LIM_W-1:0]      scan_row_r, scan_row_nxt;
  logic [LIM_W-1:0]      row_start_r, row_start_nxt;
  logic [LIM_W-1:0]      col_limit_r, col_limit_nxt;
  logic [LIM_W-1:0]      row_limit_r, row_limit_nxt;
  logic [COORD_BITS-1:0] center_col_r, center_col_nxt;
  logic [COORD_BITS-1:0] center_row_r, center_row_nxt;
  logic [RSQ_W-1:0]      rsq_r, rsq_nxt;
  logic [PIX_W-1:0]      pixel_r, pixel_nxt;

  logic [LIM_W-1:0] x_l, y_l, w_l, h_l, r_l, bw_l, bh_l;
  logic [LIM_W-1:0] c0, c_end, r0, r_end, c_lim, r_lim;
  logic [LIM_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;

  assign x_l  = LIM_W'(cmd_in.x_pos);
  assign y_l  = LIM_W'(cmd_in.y_pos);
  assign w_l  = LIM_W'(cmd_in.rect_width);
  assign h_l  = LIM_W'(cmd_in.rect_height);
  assign r_l  = LIM_W'(cmd_in.radius);
  assign bw_l = LIM_W'(bitmap_width_r);
  assign bh_l = LIM_W'(bitmap_height_r);

  // Scan box of the shape being loaded, then clipped to the bitmap.
  always_comb begin
    if (cmd_in.cmd == CMD_CIRCLE) begin
      c0    = (r_l > x_l) ? '0 : x_l - r_l;
      r0    = (r_l > y_l) ? '0 : y_l - r_l;
      c_end = x_l + r_l + LIM_W'(1);
      r_end = y_l + r_l + LIM_W'(1);
    end else begin
      c0    = x_l;
      r0    = y_l;
      c_end = x_l + w_l;
      r_end = y_l + h_l;
    end
    c_lim = (c_end < bw_l) ? c_end : bw_l;
    r_lim = (r_end < bh_l) ? r_end : bh_l;
  end

  assign col_inc  = scan_col_r + LIM_W'(1);
  assign row_inc  = scan_row_r + LIM_W'(1);
  assign col_wrap = (col_inc >= col_limit_r);
  assign row_wrap = (row_inc >= row_limit_r);

  always_comb begin
    busy_nxt       = busy_r;
    circle_nxt     = circle_r;
    scan_col_nxt   = scan_col_r;
    scan_row_nxt   = scan_row_r;
    row_start_nxt  = row_start_r;
    col_limit_nxt  = col_limit_r;
    row_limit_nxt  = row_limit_r;
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    rsq_nxt        = rsq_r;
    pixel_nxt      = pixel_r;
    push           = 1'b0;

    push_data.idle       = !busy_r;
    push_data.circle     = circle_r;
    push_data.last       = !busy_r || (col_wrap && row_wrap);
    push_data.row        = scan_row_r;
    push_data.col        = scan_col_r;
    push_data.center_col = center_col_r;
    push_data.center_row = center_row_r;
    push_data.rsq        = rsq_r;
    push_data.pixel      = pixel_r;

    if (accept) begin
      unique case (cmd_in.cmd)
        CMD_RECT, CMD_CIRCLE: begin
          circle_nxt    = (cmd_in.cmd == CMD_CIRCLE);
          pixel_nxt     = {cmd_in.alpha, cmd_in.red, cmd_in.green, cmd_in.blue};
          col_limit_nxt = c_lim;
          row_limit_nxt = r_lim;
          row_start_nxt = c0;
          scan_col_nxt  = c0;
          scan_row_nxt  = r0;
          busy_nxt      = (c0 < c_lim) && (r0 < r_lim);
          if (cmd_in.cmd == CMD_CIRCLE) begin
            center_col_nxt = cmd_in.x_pos;
            center_row_nxt = cmd_in.y_pos;
            rsq_nxt        = RSQ_W'(cmd_in.radius) * RSQ_W'(cmd_in.radius);
          end
        end
        CMD_STEP: begin
          push = 1'b1;
          if (busy_r) begin
            if (col_wrap) begin
              scan_col_nxt = row_start_r;
              if (row_wrap) begin
                busy_nxt = 1'b0;
              end else begin
                scan_row_nxt = row_inc;
              end
            end else begin
              scan_col_nxt = col_inc;
            end
          end
        end
        CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_width_r  <= BITMAP_WIDTH_RST;
      bitmap_height_r <= BITMAP_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_BITMAP_WIDTH) begin
        bitmap_width_r <= cfg_wdata;
      end else begin
        bitmap_height_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      circle_r     <= 1'b0;
      scan_col_r   <= '0;
      scan_row_r   <= '0;
      row_start_r  <= '0;
      col_limit_r  <= '0;
      row_limit_r  <= '0;
      center_col_r <= '0;
      center_row_r <= '0;
      rsq_r        <= '0;
      pixel_r      <= '0;
    end else begin
      busy_r       <= busy_nxt;
      circle_r     <= circle_nxt;
      scan_col_r   <= scan_col_nxt;
      scan_row_r   <= scan_row_nxt;
      row_start_r  <= row_start_nxt;
      col_limit_r  <= col_limit_nxt;
      row_limit_r  <= row_limit_nxt;
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
      rsq_r        <= rsq_nxt;
      pixel_r      <= pixel_nxt;
    end
  end

endmodule

// ----- src/rcfr_back.sv -----
// Coverage pipeline: squared distances, compare, and the output register.
`timescale 1ns / 1ps

module rcfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcfr_pkg::rcfr_step_t head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_we,
  output logic [rcfr_pkg::OUT_CW-1:0] out_row,
  output logic [rcfr_pkg::OUT_CW-1:0] out_col,
  output logic [rcfr_pkg::PIX_W-1:0]  out_pixel,
  output logic                 out_last
);
  import rcfr_pkg::*;

  logic                  adv;
  logic [LIM_W-1:0]      ccol_l, crow_l, dx, dy;

  // Square stage.
  logic                  s1_valid_r;
  logic                  s1_idle_r, s1_circle_r, s1_last_r;
  logic [LIM_W-1:0]      s1_row_r, s1_col_r;
  logic [RSQ_W-1:0]      s1_rsq_r;
  logic [PIX_W-1:0]      s1_pixel_r;
  logic [SQ_W-1:0]       s1_dx2_r, s1_dy2_r;

  // Compare stage feeding the output register.
  logic [SQ_W:0]         dist2;
  logic                  covered;

  logic                  out_valid_r;
  logic                  out_we_r, out_last_r;
  logic [OUT_CW-1:0]     out_row_r, out_col_r;
  logic [PIX_W-1:0]      out_pixel_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && head_valid;

  assign ccol_l = LIM_W'(head.center_col);
  assign crow_l = LIM_W'(head.center_row);
  assign dx     = (head.col >= ccol_l) ? head.col - ccol_l : ccol_l - head.col;
  assign dy     = (head.row >= crow_l) ? head.row - crow_l : crow_l - head.row;

  assign dist2   = (SQ_W + 1)'(s1_dx2_r) + (SQ_W + 1)'(s1_dy2_r);
  assign covered = !s1_idle_r && (!s1_circle_r || (dist2 < (SQ_W + 1)'(s1_rsq_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= head_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idle_r   <= head.idle;
      s1_circle_r <= head.circle;
      s1_last_r   <= head.last;
      s1_row_r    <= head.row;
      s1_col_r    <= head.col;
      s1_rsq_r    <= head.rsq;
      s1_pixel_r  <= head.pixel;
      s1_dx2_r    <= SQ_W'(dx) * SQ_W'(dx);
      s1_dy2_r    <= SQ_W'(dy) * SQ_W'(dy);

      out_we_r    <= covered;
      out_last_r  <= s1_last_r;
      out_row_r   <= s1_idle_r ? '0 : s1_row_r[OUT_CW-1:0];
      out_col_r   <= s1_idle_r ? '0 : s1_col_r[OUT_CW-1:0];
      out_pixel_r <= covered ? s1_pixel_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_we    = out_we_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

// ----- src/rect_circle_fill_rasterizer_unit.sv -----
// Top level of the rectangle and circle fill rasterizer.
`timescale 1ns / 1ps
`include "rect_circle_fill_rasterizer_unit_defines.svh"

// Rectangle and circle fill rasterizer. A rectangle or circle draw item loads
// a shape and its fill color and returns nothing; every later step item walks
// the shape's scan box (clipped to the bitmap size set through the cfg port)
// one position in raster order and returns one item that gives the position,
// whether it is covered (out_tuser), the pixel to write when it is, and
// out_tlast on the last position of the box or when no scan is active. The
// block takes one input item per clock cycle while the position queue has
// room. A step result passes through the four-entry position queue, the
// squaring stage and the compare stage that loads the output register. The
// queue lets the input keep flowing while the output is stalled, until it
// fills. Bitmap size writes must be made only while no step result is still
// pending.
module rect_circle_fill_rasterizer_unit (
  input  logic clk,
  input  logic rst_n,
  // Configuration write port: index 0 bitmap width, index 1 bitmap height.
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [rcfr_pkg::CFG_W-1:0]  cfg_wdata,
  // Input items.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // From bit 0 up: x_pos, y_pos, rect_width, rect_height, radius,
  // red, green, blue, alpha.
  input  logic [rcfr_pkg::IN_TDATA_W-1:0] in_tdata,
  // cmd.
  input  logic [rcfr_pkg::CMD_W-1:0]  in_tuser,
  // Result items.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // From bit 0 up: pixel_row, pixel_col, pixel_word.
  output logic [rcfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // write_enable.
  output logic                        out_tuser,
  // scan_done.
  output logic                        out_tlast
);
  import rcfr_pkg::*;

  localparam int ColorBase = 5 * COORD_BITS;

  rcfr_cmd_t    cmd_in;
  rcfr_step_t   push_data, head;
  rcfr_q_stat_t q_stat;
  logic         accept, q_push, q_pop;
  logic [OUT_CW-1:0] out_row, out_col;
  logic [PIX_W-1:0]  out_pixel;

  assign cmd_in.cmd         = in_tuser;
  assign cmd_in.x_pos       = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign cmd_in.y_pos       = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign cmd_in.rect_width  = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign cmd_in.rect_height = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign cmd_in.radius      = in_tdata[4*COORD_BITS +: COORD_BITS];
  assign cmd_in.red         = in_tdata[ColorBase + 0*CHAN_W +: CHAN_W];
  assign cmd_in.green       = in_tdata[ColorBase + 1*CHAN_W +: CHAN_W];
  assign cmd_in.blue        = in_tdata[ColorBase + 2*CHAN_W +: CHAN_W];
  assign cmd_in.alpha       = in_tdata[ColorBase + 3*CHAN_W +: CHAN_W];

  // Every item waits for queue room, so a step is never dropped.
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  rcfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd_in    (cmd_in),
    .push      (q_push),
    .push_data (push_data)
  );

  rcfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  rcfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_stat.valid),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_we     (out_tuser),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_pixel  (out_pixel),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_pixel, out_col, out_row};

  `RCFR_ASSERT_ALWAYS(a_queue_state, !(q_stat.full && !q_stat.valid), "queue full and empty at once")
  `RCFR_ASSERT_IMPLIES(a_push_room, q_push, !q_stat.full, "step pushed into a full queue")
  `RCFR_ASSERT_IMPLIES(a_blank_pixel, out_tvalid && !out_tuser, out_pixel == '0, "uncovered position carries a pixel value")

endmodule
